// ===== hw/rtl/rrd_pkg.sv =====
// Shared types and constants for the RESP2 reply decoder.
// Used by every module of resp_reply_decoder; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package rrd_pkg;

  // Longest bulk length kept; larger decimal lengths saturate here.
  localparam int MAX_REPLY_BYTES = 4096;
  localparam int LEN_W           = $clog2(MAX_REPLY_BYTES + 1);
  // len * 10 + 9 always fits in four more bits
  localparam int PROD_W          = LEN_W + 4;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_DIG9   = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;

  typedef enum logic [2:0] {
    PH_TYPE    = 3'd0,
    PH_STREAM  = 3'd1,
    PH_INT     = 3'd2,
    PH_SIGN    = 3'd3,
    PH_DIGITS  = 3'd4,
    PH_SKIP    = 3'd5,
    PH_BULK    = 3'd6,
    PH_DISCARD = 3'd7
  } phase_t;

  typedef enum logic [2:0] {
    KIND_STATUS = 3'd0,
    KIND_ERROR  = 3'd1,
    KIND_BULK   = 3'd2,
    KIND_INT    = 3'd3,
    KIND_NIL    = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } item_t;

  typedef struct packed {
    kind_t      reply_kind;
    logic       has_data;
    logic [7:0] payload_byte;
    logic       reply_done;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rrd_in_stage.sv =====
// Input register of the reply decoder: holds one received byte until the
// parser takes it. Depends on rrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrd_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rrd_pkg::item_t in_item,
  input  wire logic          take,
  output logic               item_valid,
  output rrd_pkg::item_t     item
);

  logic           valid_r;
  logic           valid_nxt;
  rrd_pkg::item_t item_r;

  // stall only when holding a byte the parser cannot take this cycle
  assign in_stall  = valid_r && !take;
  assign valid_nxt = in_stall ? valid_r : in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

// ===== hw/rtl/rrd_parser.sv =====
// Parse state and one-byte step of the RESP2 reply decoder.
// Depends on rrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrd_parser (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire rrd_pkg::item_t   item,
  output logic                  res_valid,
  output rrd_pkg::result_t      res
);

  rrd_pkg::phase_t            phase_r, phase_nxt;
  rrd_pkg::kind_t             type_r, type_nxt;
  logic                       neg_r, neg_nxt;
  logic [1:0]                 dc_r, dc_nxt;
  logic [rrd_pkg::LEN_W-1:0]  len_r, len_nxt;

  logic                       emit;
  rrd_pkg::result_t           res_c;
  rrd_pkg::phase_t            fin_phase;
  logic [7:0]                 b;
  logic                       fe;
  logic                       is_digit;
  logic [rrd_pkg::PROD_W-1:0] len_prod;
  logic [rrd_pkg::LEN_W-1:0]  len_dig;
  logic [1:0]                 dc_dig;
  logic [rrd_pkg::LEN_W-1:0]  len_dec;

  function automatic logic is_nil(logic neg, logic [1:0] dc,
                                  logic [rrd_pkg::LEN_W-1:0] len);
    return neg && (dc == 2'd1) && (len == rrd_pkg::LEN_W'(1));
  endfunction

  function automatic rrd_pkg::result_t mk_res(rrd_pkg::kind_t kind, logic data,
                                              logic [7:0] pb, logic done);
    rrd_pkg::result_t r;
    r.reply_kind   = kind;
    r.has_data     = data;
    r.payload_byte = data ? pb : 8'h00;
    r.reply_done   = done;
    return r;
  endfunction

  assign b         = item.data_byte;
  assign fe        = item.frame_end;
  assign fin_phase = fe ? rrd_pkg::PH_TYPE : rrd_pkg::PH_DISCARD;
  assign is_digit  = (b >= rrd_pkg::CH_DIG0) && (b <= rrd_pkg::CH_DIG9);

  // len * 10 + digit, saturated
  assign len_prod = rrd_pkg::PROD_W'({len_r, 3'b000}) + rrd_pkg::PROD_W'({len_r, 1'b0})
                  + rrd_pkg::PROD_W'(b[3:0]);
  assign len_dig  = (len_prod > rrd_pkg::PROD_W'(rrd_pkg::MAX_REPLY_BYTES))
                  ? rrd_pkg::LEN_W'(rrd_pkg::MAX_REPLY_BYTES)
                  : len_prod[rrd_pkg::LEN_W-1:0];
  assign dc_dig   = (dc_r == 2'd2) ? 2'd2 : dc_r + 2'd1;
  assign len_dec  = (len_r != '0) ? len_r - rrd_pkg::LEN_W'(1) : len_r;

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    neg_nxt   = neg_r;
    dc_nxt    = dc_r;
    len_nxt   = len_r;
    emit      = 1'b0;
    res_c     = mk_res(rrd_pkg::KIND_STATUS, 1'b0, 8'h00, 1'b0);

    unique case (phase_r) inside
      rrd_pkg::PH_TYPE: begin
        neg_nxt = 1'b0;
        dc_nxt  = 2'd0;
        len_nxt = '0;
        if (b == rrd_pkg::CH_PLUS || b == rrd_pkg::CH_MINUS ||
            b == rrd_pkg::CH_COLON || b == rrd_pkg::CH_DOLLAR) begin
          if (b == rrd_pkg::CH_PLUS) begin
            type_nxt  = rrd_pkg::KIND_STATUS;
            phase_nxt = rrd_pkg::PH_STREAM;
          end else if (b == rrd_pkg::CH_MINUS) begin
            type_nxt  = rrd_pkg::KIND_ERROR;
            phase_nxt = rrd_pkg::PH_STREAM;
          end else if (b == rrd_pkg::CH_COLON) begin
            type_nxt  = rrd_pkg::KIND_INT;
            phase_nxt = rrd_pkg::PH_INT;
          end else begin
            type_nxt  = rrd_pkg::KIND_BULK;
            phase_nxt = rrd_pkg::PH_SIGN;
          end
          if (fe) begin
            phase_nxt = fin_phase;
            emit      = 1'b1;
            res_c     = mk_res(type_nxt, 1'b0, 8'h00, 1'b1);
          end
        end else begin
          // unknown type byte, including an empty response: drop the buffer
          phase_nxt = fin_phase;
        end
      end

      rrd_pkg::PH_STREAM, rrd_pkg::PH_INT, rrd_pkg::PH_BULK: begin
        emit = 1'b1;
        if (b == rrd_pkg::CH_NUL ||
            (phase_r == rrd_pkg::PH_INT && b == rrd_pkg::CH_CR)) begin
          phase_nxt = fin_phase;
          res_c     = mk_res(type_r, 1'b0, 8'h00, 1'b1);
        end else if (phase_r == rrd_pkg::PH_BULK) begin
          len_nxt = len_dec;
          if (fe || len_dec == '0) begin
            phase_nxt = fin_phase;
          end
          res_c = mk_res(type_r, 1'b1, b, fe || len_dec == '0);
        end else begin
          if (fe) begin
            phase_nxt = fin_phase;
          end
          res_c = mk_res(type_r, 1'b1, b, fe);
        end
      end

      rrd_pkg::PH_SIGN, rrd_pkg::PH_DIGITS: begin
        phase_nxt = rrd_pkg::PH_DIGITS;
        if (phase_r == rrd_pkg::PH_SIGN && b == rrd_pkg::CH_MINUS) begin
          neg_nxt = 1'b1;
          if (fe) begin
            phase_nxt = fin_phase;
            emit      = 1'b1;
            res_c     = mk_res(is_nil(1'b1, dc_r, len_r) ? rrd_pkg::KIND_NIL
                                                         : rrd_pkg::KIND_BULK,
                               1'b0, 8'h00, 1'b1);
          end
        end else if (is_digit) begin
          len_nxt = len_dig;
          dc_nxt  = dc_dig;
          if (fe) begin
            phase_nxt = fin_phase;
            emit      = 1'b1;
            res_c     = mk_res(is_nil(neg_r, dc_dig, len_dig) ? rrd_pkg::KIND_NIL
                                                              : rrd_pkg::KIND_BULK,
                               1'b0, 8'h00, 1'b1);
          end
        end else if (is_nil(neg_r, dc_r, len_r) || b == rrd_pkg::CH_NUL || fe) begin
          phase_nxt = fin_phase;
          emit      = 1'b1;
          res_c     = mk_res(is_nil(neg_r, dc_r, len_r) ? rrd_pkg::KIND_NIL
                                                        : rrd_pkg::KIND_BULK,
                             1'b0, 8'h00, 1'b1);
        end else begin
          // the byte that ends the digits is skipped, and the next one too
          phase_nxt = rrd_pkg::PH_SKIP;
        end
      end

      rrd_pkg::PH_SKIP: begin
        if (b == rrd_pkg::CH_NUL || fe || (!neg_r && len_r == '0)) begin
          phase_nxt = fin_phase;
          emit      = 1'b1;
          res_c     = mk_res(rrd_pkg::KIND_BULK, 1'b0, 8'h00, 1'b1);
        end else begin
          // negative length other than nil: payload runs to buffer end
          phase_nxt = neg_r ? rrd_pkg::PH_STREAM : rrd_pkg::PH_BULK;
        end
      end

      rrd_pkg::PH_DISCARD: begin
        if (fe) begin
          phase_nxt = rrd_pkg::PH_TYPE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rrd_pkg::PH_TYPE;
      type_r  <= rrd_pkg::KIND_STATUS;
      neg_r   <= 1'b0;
      dc_r    <= 2'd0;
      len_r   <= '0;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      neg_r   <= neg_nxt;
      dc_r    <= dc_nxt;
      len_r   <= len_nxt;
    end
  end

  assign res_valid = step_en && emit;
  assign res       = res_c;

endmodule

`default_nettype wire

// ===== hw/rtl/rrd_out_stage.sv =====
// Result register of the reply decoder: holds one result until the
// receiver takes it. Depends on rrd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rrd_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire rrd_pkg::result_t res,
  output logic                  ready,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output rrd_pkg::result_t      out_res
);

  logic             valid_r;
  logic             valid_nxt;
  rrd_pkg::result_t res_r;

  // free when empty or when the held result leaves at this edge
  assign ready     = !valid_r || !out_stall;
  assign valid_nxt = ready ? push : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && push) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

`default_nettype wire

// ===== hw/rtl/resp_reply_decoder.sv =====
// A byte accepted into the input register is parsed combinationally; its result
// enters the output register at the edge where the parse step is enabled.
// Throughput: one byte per cycle while the receiver takes results; a stalled
// result lets one more byte into the input register, then stalls the input.
// Reset (rst_n low, synchronous): parser back to awaiting a type byte, length
// state cleared, input and result registers emptied.
// Top level; depends on rrd_pkg, rrd_in_stage, rrd_parser, rrd_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module resp_reply_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_frame_end,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_reply_kind,
  output logic            out_has_data,
  output logic [7:0]      out_payload_byte,
  output logic            out_reply_done
);

  rrd_pkg::item_t   in_item;
  rrd_pkg::item_t   item;
  logic             item_valid;
  logic             out_ready;
  logic             step_en;
  logic             res_valid;
  rrd_pkg::result_t res;
  rrd_pkg::result_t out_res;

  assign in_item.data_byte = in_data_byte;
  assign in_item.frame_end = in_frame_end;

  // parse step advances only when the result register can take its output
  assign step_en = item_valid && out_ready;

  rrd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (out_ready),
    .item_valid (item_valid),
    .item       (item)
  );

  rrd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  rrd_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .res       (res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_reply_kind   = out_res.reply_kind;
  assign out_has_data     = out_res.has_data;
  assign out_payload_byte = out_res.payload_byte;
  assign out_reply_done   = out_res.reply_done;

endmodule

`default_nettype wire

// ===== hw/rtl/rrd_checker.sv =====
// Port-level checks for resp_reply_decoder, bound to the top level.
// Depends on rrd_pkg and resp_reply_decoder.
`timescale 1ns / 1ps
`default_nettype none

module rrd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] in_data_byte,
  input wire logic       in_frame_end,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_reply_kind,
  input wire logic       out_has_data,
  input wire logic [7:0] out_payload_byte,
  input wire logic       out_reply_done
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_reply_kind) &&
    $stable(out_has_data) && $stable(out_payload_byte) && $stable(out_reply_done))
    else $error("result changed while stalled");

  // input backpressure only comes from a blocked result register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // a result without payload always closes the reply
  a_empty_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_data |-> out_reply_done && out_payload_byte == 8'h00)
    else $error("dataless result not marked done");

  a_nil_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_reply_kind == 3'(rrd_pkg::KIND_NIL) |-> !out_has_data)
    else $error("nil result carries data");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind resp_reply_decoder rrd_checker u_rrd_checker (.*);

`default_nettype wire
